@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge unless the disable term is high.
`define HLMV_ASSERT(lbl, clk, dis, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (prop)) else $error(msg);

// Condition must never be seen at a rising edge unless the disable term is high.
`define HLMV_NEVER(lbl, clk, dis, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) !(cond)) else $error(msg);

`endif

@@ hdl/hlmv_pkg.sv @@
// Types and constants shared by the max-violator pipeline.
`timescale 1ns / 1ps
`default_nettype none

package hlmv_pkg;

   localparam int VAL_W  = 32;
   localparam int ACC_W  = 64;
   localparam int IDX_W  = 8;
   localparam int EX_W   = 10;
   localparam int CNUM_W = 16;
   localparam int LOSS_W = 31;
   localparam int ECNT_W = 11;
   localparam int FCNT_W = 9;

   localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

   localparam logic [ECNT_W-1:0] EXAMPLE_COUNT_RST = 11'd1024;
   localparam logic [FCNT_W-1:0] FEATURE_COUNT_RST = 9'd256;

   // csr register indexes
   localparam logic CSR_EXAMPLE_COUNT = 1'b0;
   localparam logic CSR_FEATURE_COUNT = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_FEED = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // accepted command word plus range checks done at the input
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [IDX_W-1:0]  eidx;
      logic [VAL_W-1:0]  val;
      logic [VAL_W-1:0]  margin;
      logic [EX_W-1:0]   ex;
      logic              ex_ok;
      logic [CNUM_W-1:0] cnum;
      logic              last;
      logic              feat_ok;
   } req_type;

   // finished dot product or read request leaving the MAC
   typedef struct packed {
      logic              valid;
      logic              is_read;
      logic [EX_W-1:0]   ex;
      logic              ex_ok;
      logic [CNUM_W-1:0] cnum;
      logic [VAL_W-1:0]  margin;
      logic [ACC_W-1:0]  dot;
   } dot_type;

   // clamped loss or read request entering the table
   typedef struct packed {
      logic              valid;
      logic              is_read;
      logic [EX_W-1:0]   ex;
      logic              ex_ok;
      logic [CNUM_W-1:0] cnum;
      logic [LOSS_W-1:0] loss;
   } loss_item_type;

   typedef struct packed {
      logic [LOSS_W-1:0] loss;
      logic [CNUM_W-1:0] winner;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic [EX_W-1:0]   ex;
      logic [LOSS_W-1:0] loss;
      logic [CNUM_W-1:0] winner;
      logic              status;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/hinge_loss_max_violator.sv @@
// Throughput: one word per cycle (load, feature or read) while busy is low.
// A read word strobes its result at the end of the 6-stage pipe of weight read,
// multiply, accumulate, loss, table read and table write.
// Reset: synchronous; clears the pipe and the accumulator, then busy stays high
// while the example table's min(MAX_EXAMPLES, 1024) entries are swept to zero.
// Results cannot be stalled; configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module hinge_loss_max_violator #(
   parameter int MAX_FEATURES = 256,
   parameter int MAX_EXAMPLES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // command word
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_element_index,
   input  logic [31:0] req_element_value,
   input  logic [31:0] req_margin,
   input  logic [9:0]  req_example_index,
   input  logic [15:0] req_constraint_number,
   input  logic        req_last_feature,
   // result word
   output logic        rsp_valid,
   output logic [9:0]  rsp_read_example,
   output logic [30:0] rsp_worst_loss,
   output logic [15:0] rsp_worst_constraint,
   output logic        rsp_status,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);
   import hlmv_pkg::*;

   logic [ECNT_W-1:0] example_count_ff;
   logic [FCNT_W-1:0] feature_count_ff;
   logic              accept;
   logic              clearing;
   req_type           req;
   dot_type           dot_item;
   loss_item_type     loss_item;
   rsp_type           rsp;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         example_count_ff <= EXAMPLE_COUNT_RST;
         feature_count_ff <= FEATURE_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_EXAMPLE_COUNT) begin
            example_count_ff <= csr_data;
         end
         if (csr_index == CSR_FEATURE_COUNT) begin
            feature_count_ff <= csr_data[FCNT_W-1:0];
         end
      end
   end

   // accept and range checks
   assign busy   = clearing;
   assign accept = start && !busy;

   always_comb begin
      req.valid   = accept;
      req.op      = op_type'(req_opcode);
      req.eidx    = req_element_index;
      req.val     = req_element_value;
      req.margin  = req_margin;
      req.ex      = req_example_index;
      req.cnum    = req_constraint_number;
      req.last    = req_last_feature;
      req.ex_ok   = ({1'b0, req_example_index} < example_count_ff) &&
                    ({{(32-EX_W){1'b0}}, req_example_index} < 32'(MAX_EXAMPLES));
      req.feat_ok = ({1'b0, req_element_index} < feature_count_ff) &&
                    ({{(32-IDX_W){1'b0}}, req_element_index} < 32'(MAX_FEATURES));
   end

   hlmv_mac #(
      .MAX_FEATURES(MAX_FEATURES)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .dot_out (dot_item)
   );

   hlmv_loss u_loss (
      .clock    (clock),
      .reset    (reset),
      .dot_in   (dot_item),
      .loss_out (loss_item)
   );

   hlmv_table #(
      .MAX_EXAMPLES(MAX_EXAMPLES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .item     (loss_item),
      .clearing (clearing),
      .rsp      (rsp)
   );

   assign rsp_valid            = rsp.valid;
   assign rsp_read_example     = rsp.ex;
   assign rsp_worst_loss       = rsp.loss;
   assign rsp_worst_constraint = rsp.winner;
   assign rsp_status           = rsp.status;

endmodule

`default_nettype wire

@@ hdl/hlmv_mac.sv @@
// Weight store, multiplier and dot-product accumulator.
`timescale 1ns / 1ps
`default_nettype none

module hlmv_mac #(
   parameter int MAX_FEATURES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  hlmv_pkg::req_type req,
   output hlmv_pkg::dot_type dot_out
);
   import hlmv_pkg::*;

   localparam int WDEPTH = (MAX_FEATURES < (1 << IDX_W)) ? MAX_FEATURES : (1 << IDX_W);
   localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

   logic [VAL_W-1:0] wmem [WDEPTH];
   logic [WAW-1:0]   waddr;
   logic             wr_en;
   logic [VAL_W-1:0] wrd_ff;

   req_type            s1_ff;
   req_type            s1_in;
   req_type            s2_ff;
   logic signed [ACC_W-1:0] prod_full;
   logic signed [ACC_W-1:0] prod_in;
   logic signed [ACC_W-1:0] prod_ff;
   logic [ACC_W-1:0]   sum;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   acc_in;
   dot_type            dot_ff;
   dot_type            dot_in;

   // weight store: loads write, feature words read
   assign waddr = req.eidx[WAW-1:0];
   assign wr_en = req.valid && (req.op == OP_LOAD) &&
                  ({{(32-IDX_W){1'b0}}, req.eidx} < 32'(MAX_FEATURES));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[waddr] <= req.val;
      end
      wrd_ff <= wmem[waddr];
   end

   // only feature and read words travel down the pipe
   always_comb begin
      s1_in       = req;
      s1_in.valid = req.valid && ((req.op == OP_FEED) || (req.op == OP_READ));
   end

   // stage 1 -> 2: one signed 32x32 product
   assign prod_full = $signed(wrd_ff) * $signed(s1_ff.val);
   assign prod_in   = s1_ff.feat_ok ? prod_full : 64'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
      end
      prod_ff <= prod_in;
   end

   // stage 2 -> 3: accumulate, clear on the last element
   assign sum = acc_ff + prod_ff;

   always_comb begin
      acc_in = acc_ff;
      if (s2_ff.valid && (s2_ff.op == OP_FEED)) begin
         acc_in = s2_ff.last ? '0 : sum;
      end
      dot_in.valid   = s2_ff.valid && ((s2_ff.op == OP_READ) || s2_ff.last);
      dot_in.is_read = (s2_ff.op == OP_READ);
      dot_in.ex      = s2_ff.ex;
      dot_in.ex_ok   = s2_ff.ex_ok;
      dot_in.cnum    = s2_ff.cnum;
      dot_in.margin  = s2_ff.margin;
      dot_in.dot     = sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         dot_ff.valid <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         dot_ff <= dot_in;
      end
   end

   assign dot_out = dot_ff;

endmodule

`default_nettype wire

@@ hdl/hlmv_loss.sv @@
// Hinge loss: margin minus dot product, clamped at zero and saturated.
`timescale 1ns / 1ps
`default_nettype none

module hlmv_loss (
   input  logic                    clock,
   input  logic                    reset,
   input  hlmv_pkg::dot_type       dot_in,
   output hlmv_pkg::loss_item_type loss_out
);
   import hlmv_pkg::*;

   logic [ACC_W-1:0] marg_q32;
   logic [ACC_W-1:0] diff;
   loss_item_type    loss_ff;
   loss_item_type    loss_in;

   // margin moved to Q48.16, then one wide subtract
   assign marg_q32 = {{(ACC_W-VAL_W-16){dot_in.margin[VAL_W-1]}}, dot_in.margin, 16'd0};
   assign diff     = marg_q32 - dot_in.dot;

   always_comb begin
      loss_in.valid   = dot_in.valid;
      loss_in.is_read = dot_in.is_read;
      loss_in.ex      = dot_in.ex;
      loss_in.ex_ok   = dot_in.ex_ok;
      loss_in.cnum    = dot_in.cnum;
      // negative -> 0, too big -> max, else drop the fraction bits
      if (diff[ACC_W-1]) begin
         loss_in.loss = '0;
      end else if (|diff[ACC_W-2:LOSS_W+16]) begin
         loss_in.loss = LOSS_MAX;
      end else begin
         loss_in.loss = diff[LOSS_W+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_ff.valid <= 1'b0;
      end else begin
         loss_ff <= loss_in;
      end
   end

   assign loss_out = loss_ff;

endmodule

`default_nettype wire

@@ hdl/hlmv_table.sv @@
// Per-example worst-loss table with read-modify-write and clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module hlmv_table #(
   parameter int MAX_EXAMPLES = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hlmv_pkg::loss_item_type item,
   output logic                    clearing,
   output hlmv_pkg::rsp_type       rsp
);
   import hlmv_pkg::*;

   localparam int EDEPTH = (MAX_EXAMPLES < (1 << EX_W)) ? MAX_EXAMPLES : (1 << EX_W);
   localparam int EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
   localparam logic [EAW-1:0] CLR_LAST = EAW'(EDEPTH - 1);

   entry_type     tmem [EDEPTH];
   entry_type     rd_ff;
   state_type     state_ff;
   state_type     state_in;
   logic [EAW-1:0] clr_addr_ff;
   logic [EAW-1:0] clr_addr_in;

   loss_item_type s5_ff;
   entry_type     cur;
   entry_type     upd_data;
   logic          upd_we;
   logic          fwd_hit_ff;
   logic          fwd_hit_in;
   entry_type     fwd_ff;

   logic          mem_we;
   logic [EAW-1:0] mem_waddr;
   entry_type     mem_wdata;

   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   // clearing pass after reset, one entry a cycle
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            clr_addr_in = '0;
         end
         default: begin
            state_in    = ST_CLEAR;
            clr_addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign clearing = (state_ff == ST_CLEAR);

   // entry seen by the stage-5 word; the previous word's write is forwarded
   assign cur = fwd_hit_ff ? fwd_ff : rd_ff;

   always_comb begin
      upd_we   = 1'b0;
      upd_data = '0;
      if (s5_ff.valid && s5_ff.ex_ok) begin
         if (s5_ff.is_read) begin
            upd_we = 1'b1;
         end else if (s5_ff.loss >= cur.loss) begin
            upd_we          = 1'b1;
            upd_data.loss   = s5_ff.loss;
            upd_data.winner = s5_ff.cnum;
         end
      end
   end

   assign fwd_hit_in = upd_we && item.valid && (item.ex == s5_ff.ex);

   // single write port shared with the clearing pass
   assign mem_we    = clearing || upd_we;
   assign mem_waddr = clearing ? clr_addr_ff : s5_ff.ex[EAW-1:0];
   assign mem_wdata = clearing ? '0 : upd_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tmem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= tmem[item.ex[EAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ff.valid <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s5_ff      <= item;
         fwd_hit_ff <= fwd_hit_in;
      end
      fwd_ff <= upd_data;
   end

   // result word, registered
   always_comb begin
      rsp_in.valid  = s5_ff.valid && s5_ff.is_read;
      rsp_in.ex     = s5_ff.ex;
      rsp_in.loss   = s5_ff.ex_ok ? cur.loss : '0;
      rsp_in.winner = s5_ff.ex_ok ? cur.winner : '0;
      rsp_in.status = !s5_ff.ex_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/hlmv_checker.sv @@
// Port-level checks for the max-violator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hlmv_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_opcode,
   input logic [9:0]  req_example_index,
   input logic        rsp_valid,
   input logic [9:0]  rsp_read_example,
   input logic [30:0] rsp_worst_loss,
   input logic [15:0] rsp_worst_constraint,
   input logic        rsp_status
);
   import hlmv_pkg::*;

   logic read_acc;

   assign read_acc = start && !busy && (req_opcode == OP_READ);

   // reset starts the table sweep
   `HLMV_ASSERT(a_reset_sweep, clock, 1'b0, reset |=> busy, "no clearing pass after reset")
   // an out-of-range read reports an empty entry
   `HLMV_ASSERT(a_status_empty, clock, reset,
      (rsp_valid && rsp_status) |-> (rsp_worst_loss == '0 && rsp_worst_constraint == '0),
      "out-of-range read returned data")
   // every accepted read strobes its result
   `HLMV_ASSERT(a_read_answered, clock, reset, read_acc |-> ##6 rsp_valid, "read lost")
   // every result comes from an accepted read of the same example
   `HLMV_ASSERT(a_rsp_sourced, clock, reset,
      rsp_valid |-> ($past(read_acc, 6) && rsp_read_example == $past(req_example_index, 6)),
      "result without matching read")
   // nothing comes out during the sweep
   `HLMV_NEVER(a_quiet_sweep, clock, reset, rsp_valid && busy, "result during clearing pass")

endmodule

bind hinge_loss_max_violator hlmv_checker u_hlmv_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_opcode           (req_opcode),
   .req_example_index    (req_example_index),
   .rsp_valid            (rsp_valid),
   .rsp_read_example     (rsp_read_example),
   .rsp_worst_loss       (rsp_worst_loss),
   .rsp_worst_constraint (rsp_worst_constraint),
   .rsp_status           (rsp_status)
);

`default_nettype wire
